// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Widths, codes and control types shared by the priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DepthDefault = 16;
  localparam int KeyW         = 48;
  localparam int PayW         = 32;
  localparam int StatusW      = 2;
  localparam int CountOutW    = 5;

  // Operation codes carried in the input tuser.
  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic push;
    logic pop;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts beats and tracks the result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);
  import spq_pkg::*;

  localparam logic [0:0] SIdle = 1'b0;
  localparam logic [0:0] SHold = 1'b1;

  logic [0:0] state_q, state_d;
  logic       accept;

  // A new beat may enter whenever the result register is free or being drained.
  assign in_ready_o  = (state_q == SIdle) || out_ready_i;
  assign out_valid_o = (state_q == SHold);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) state_d = SHold;
      end
      SHold: begin
        if (accept) state_d = SHold;
        else if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    cmd_o.load = accept;
    cmd_o.push = accept && (op_i == OpPush) && !stat_i.full;
    cmd_o.pop  = accept && (op_i == OpPop) && !stat_i.empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted shift-register slots, entry count and the result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int Depth = spq_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::spq_cmd_t                 cmd_i,
  input  logic                              op_i,
  input  logic [spq_pkg::KeyW-1:0]          key_i,
  input  logic [spq_pkg::PayW-1:0]          payload_i,
  output spq_pkg::spq_stat_t                stat_o,
  output logic [spq_pkg::StatusW-1:0]       status_o,
  output logic [spq_pkg::KeyW-1:0]          out_key_o,
  output logic [spq_pkg::PayW-1:0]          out_payload_o,
  output logic [spq_pkg::CountOutW-1:0]     entry_count_o,
  output logic                              is_empty_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(Depth + 1);

  logic [KeyW-1:0] key_q [Depth];
  logic [KeyW-1:0] key_d [Depth];
  logic [PayW-1:0] pay_q [Depth];
  logic [PayW-1:0] pay_d [Depth];
  logic [Depth-1:0] stay;

  logic [CntW-1:0] count_q, count_d;

  logic [StatusW-1:0]   status_q, status_d;
  logic [KeyW-1:0]      okey_q;
  logic [PayW-1:0]      opay_q;
  logic [CntW-1:0]      ocnt_q;
  logic                 oempty_q;
  logic [CntW+CountOutW-1:0] ocnt_ext;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);

  // Each slot decides on its own: held entries with a key not above the new
  // one stay, the first slot past them takes the new entry, the rest shift up.
  for (genvar i = 0; i < Depth; i++) begin : g_slot
    logic [KeyW-1:0] lo_key, hi_key;
    logic [PayW-1:0] lo_pay, hi_pay;
    logic            take_new;

    assign stay[i] = (CntW'(i) < count_q) && (key_q[i] <= key_i);

    if (i == 0) begin : g_first
      assign lo_key   = key_i;
      assign lo_pay   = payload_i;
      assign take_new = 1'b1;
    end else begin : g_rest
      assign lo_key   = key_q[i-1];
      assign lo_pay   = pay_q[i-1];
      assign take_new = stay[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign hi_key = key_q[i];
      assign hi_pay = pay_q[i];
    end else begin : g_inner
      assign hi_key = key_q[i+1];
      assign hi_pay = pay_q[i+1];
    end

    always_comb begin
      key_d[i] = key_q[i];
      pay_d[i] = pay_q[i];
      if (cmd_i.push && !stay[i]) begin
        if (take_new) begin
          key_d[i] = key_i;
          pay_d[i] = payload_i;
        end else begin
          key_d[i] = lo_key;
          pay_d[i] = lo_pay;
        end
      end else if (cmd_i.pop) begin
        key_d[i] = hi_key;
        pay_d[i] = hi_pay;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      key_q[i] <= key_d[i];
      pay_q[i] <= pay_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) count_d = count_q + CntW'(1);
    else if (cmd_i.pop) count_d = count_q - CntW'(1);
  end

  always_comb begin
    status_d = StDone;
    if (op_i == OpPush) begin
      if (stat_o.full) status_d = StFull;
    end else begin
      if (stat_o.empty) status_d = StEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_d;
      okey_q   <= cmd_i.pop ? key_q[0] : '0;
      opay_q   <= cmd_i.pop ? pay_q[0] : '0;
      ocnt_q   <= count_d;
      oempty_q <= (count_d == '0);
    end
  end

  assign ocnt_ext      = (CntW + CountOutW)'(ocnt_q);
  assign status_o      = status_q;
  assign out_key_o     = okey_q;
  assign out_payload_o = opay_q;
  assign entry_count_o = ocnt_ext[CountOutW-1:0];
  assign is_empty_o    = oempty_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded, stable minimum priority queue of (key, payload) entries.
// ----------------------------------------------------------------------------
// Usage: each input beat is one operation. s_axis_tuser_i selects push (0) or
// pop (1); a push carries its key and payload in s_axis_tdata_i. Entries are
// kept sorted in a row of shift-register slots, ascending by key, and a push
// lands behind every held entry with an equal or smaller key, so equal keys
// leave in arrival order. A pop returns the front slot.
// Every input beat yields exactly one output beat with a status (done, pop
// on empty, push dropped because full), the popped key and payload (zero
// otherwise), the entry count after the operation and an empty flag.
// The result appears in the output register on the cycle after the input
// beat is accepted. Throughput is one beat per cycle while the receiver
// keeps up, set by the single compare-and-shift step of the slot row.
// When the receiver stalls, the result is held and every new beat is refused
// until it drains; a beat may enter in the same cycle the result leaves.
// Reset empties the queue at once; slot contents are not cleared, since only
// slots below the entry count are ever read.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,   // [47:0] key, [79:48] payload
  input  logic        s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o    // [1:0] status, [49:2] out_key,
                                        // [81:50] out_payload,
                                        // [86:82] entry_count, [87] is_empty
);
  import spq_pkg::*;

  `include "assert_macros.svh"

  spq_cmd_t  cmd;
  spq_stat_t stat;

  logic [StatusW-1:0]   status;
  logic [KeyW-1:0]      out_key;
  logic [PayW-1:0]      out_payload;
  logic [CountOutW-1:0] entry_count;
  logic                 is_empty;

  // The controller owns the handshake and issues one command per accepted beat.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the sorted slots, the count and the result register.
  spq_datapath #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (s_axis_tuser_i),
    .key_i         (s_axis_tdata_i[KeyW-1:0]),
    .payload_i     (s_axis_tdata_i[KeyW+PayW-1:KeyW]),
    .stat_o        (stat),
    .status_o      (status),
    .out_key_o     (out_key),
    .out_payload_o (out_payload),
    .entry_count_o (entry_count),
    .is_empty_o    (is_empty)
  );

  assign m_axis_tdata_o = {is_empty, entry_count, out_payload, out_key, status};

  // A queue holding DEPTH entries can never look empty.
  `SPQ_ASSERT_IMP(a_full_not_empty, stat.full, !stat.empty, "queue both full and empty")

  // A push that is taken reports done on the next cycle.
  `SPQ_ASSERT_NXT(a_push_done, cmd.push, m_axis_tvalid_o && (status == StDone) && !is_empty, "push not reported as done")

  // A pop on an empty queue reports empty with a zero key.
  `SPQ_ASSERT_NXT(a_pop_empty, cmd.load && !cmd.pop && (s_axis_tuser_i == OpPop), (status == StEmpty) && (out_key == '0) && is_empty, "empty pop misreported")

endmodule
